// File: src/tsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_pkg
// shared types and constants of the type-length-value stream deframer
// ----------------------------------------------------------------------------
package tsd_pkg;

  // header sizes, type byte included
  localparam int HDR_LONG_BYTES  = 5;
  localparam int HDR_SHORT_BYTES = 3;

  // default depth of the queue between parser and output stage
  localparam int QUEUE_DEPTH_DEF = 4;

  // one result of the deframer
  typedef struct packed {
    logic [7:0] packet_type;
    logic [7:0] payload_byte;
    logic       first_of_packet;
    logic       last_of_packet;
    logic       empty_packet;
  } tsd_rec_t;

endpackage

// File: src/tsd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_front
// header parser: walks type, length and payload bytes, builds result records
// ----------------------------------------------------------------------------
module tsd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_accept,
  input  logic [7:0]        in_byte,
  input  logic              long_length_type_we,
  input  logic [7:0]        long_length_type,
  output logic              rec_valid,
  output tsd_pkg::tsd_rec_t rec
);
  import tsd_pkg::*;

  localparam logic [1:0] PH_TYPE = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_PAY  = 2'd2;

  logic [7:0]  long_type;
  logic [1:0]  phase, phase_next;
  logic [7:0]  held_type, held_type_next;
  logic [2:0]  len_left, len_left_next;
  logic [31:0] len_accum, len_accum_next;
  logic [31:0] payload_left, payload_left_next;
  logic        at_first, at_first_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_type <= 8'd0;
    end else if (long_length_type_we) begin
      long_type <= long_length_type;
    end
  end

  always_comb begin
    phase_next        = phase;
    held_type_next    = held_type;
    len_left_next     = len_left;
    len_accum_next    = len_accum;
    payload_left_next = payload_left;
    at_first_next     = at_first;
    rec_valid         = 1'b0;
    rec               = '0;
    rec.packet_type   = held_type;
    if (in_accept) begin
      case (phase)
        PH_LEN: begin
          len_accum_next = {len_accum[23:0], in_byte};
          len_left_next  = len_left - 3'd1;
          if (len_left_next == 3'd0) begin
            if (len_accum_next == 32'd0) begin
              phase_next          = PH_TYPE;
              rec_valid           = 1'b1;
              rec.first_of_packet = 1'b1;
              rec.last_of_packet  = 1'b1;
              rec.empty_packet    = 1'b1;
            end else begin
              payload_left_next = len_accum_next;
              at_first_next     = 1'b1;
              phase_next        = PH_PAY;
            end
          end
        end
        PH_PAY: begin
          rec_valid           = 1'b1;
          rec.payload_byte    = in_byte;
          rec.first_of_packet = at_first;
          rec.last_of_packet  = (payload_left == 32'd1);
          payload_left_next   = payload_left - 32'd1;
          at_first_next       = 1'b0;
          if (payload_left == 32'd1) begin
            phase_next    = PH_TYPE;
            at_first_next = 1'b1;
          end
        end
        default: begin
          // type byte; the unused phase code lands here too
          held_type_next = in_byte;
          len_left_next  = (in_byte == long_type) ? 3'(HDR_LONG_BYTES - 1)
                                                  : 3'(HDR_SHORT_BYTES - 1);
          len_accum_next = 32'd0;
          phase_next     = PH_LEN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_TYPE;
      held_type    <= 8'd0;
      len_left     <= 3'd0;
      len_accum    <= 32'd0;
      payload_left <= 32'd0;
      at_first     <= 1'b1;
    end else begin
      phase        <= phase_next;
      held_type    <= held_type_next;
      len_left     <= len_left_next;
      len_accum    <= len_accum_next;
      payload_left <= payload_left_next;
      at_first     <= at_first_next;
    end
  end

  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec.empty_packet |->
      rec.first_of_packet && rec.last_of_packet && rec.payload_byte == 8'd0)
    else $error("empty marker not flagged as a whole packet");

  a_last_ends_packet: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec.last_of_packet |=> phase == PH_TYPE)
    else $error("parser did not return to type byte after last result");

  a_len_count_live: assert property (@(posedge clk) disable iff (rst)
    phase == PH_LEN |-> len_left != 3'd0)
    else $error("collecting length bytes with nothing left to collect");

endmodule

// File: src/tsd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_queue
// short queue of result records between parser and output stage
// ----------------------------------------------------------------------------
module tsd_queue #(
  parameter int DEPTH = tsd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  tsd_pkg::tsd_rec_t wr_data,
  output logic              full,
  input  logic              rd_en,
  output logic              not_empty,
  output tsd_pkg::tsd_rec_t rd_data
);
  import tsd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tsd_rec_t        slots [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_wr, do_rd;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_wr     = wr_en && !full;
  assign do_rd     = rd_en && not_empty;
  assign rd_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full)
    else $error("request offered to a full queue");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    do_wr && !do_rd |=> count == $past(count) + CW'(1))
    else $error("queue count did not follow a write");

endmodule

// File: src/tsd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_back
// output stage: holds the oldest result until the consumer pops it
// ----------------------------------------------------------------------------
module tsd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_not_empty,
  input  tsd_pkg::tsd_rec_t q_data,
  output logic              q_rd,
  input  logic              pop,
  output logic              empty,
  output tsd_pkg::tsd_rec_t out_rec
);
  import tsd_pkg::*;

  logic out_valid;

  // refill when the register is free or being taken this cycle
  assign q_rd  = q_not_empty && (!out_valid || pop);
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_rd) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      out_rec <= q_data;
    end
  end

endmodule

// File: src/tlv_stream_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlv_stream_deframer_unit
// splits a byte stream into type-length-value packets, one result per
// payload byte, tagged with the packet type
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  input     push / full        in_byte
//  result    pop / empty        packet_type, payload_byte, first_of_packet,
//                               last_of_packet, empty_packet
//  config    long_length_type_we long_length_type
//
//  one byte per cycle in while full is low; a result passes from the parser
//  through the queue into the output register (parser, queue, output register)
//  the parser loop over type, length and payload state sets the rate
//  full rises only when QUEUE_DEPTH results plus the output register wait
//  rst is synchronous; after it the parser waits for a type byte
// ----------------------------------------------------------------------------
module tlv_stream_deframer_unit #(
  parameter int QUEUE_DEPTH = tsd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] packet_type,
  output logic [7:0] payload_byte,
  output logic       first_of_packet,
  output logic       last_of_packet,
  output logic       empty_packet,
  input  logic       long_length_type_we,
  input  logic [7:0] long_length_type
);
  import tsd_pkg::*;

  logic     in_accept;
  logic     rec_valid;
  tsd_rec_t rec;
  logic     q_not_empty;
  logic     q_rd;
  tsd_rec_t q_data;
  tsd_rec_t out_rec;

  assign in_accept = push && !full;

  tsd_front u_front (
    .clk                 (clk),
    .rst                 (rst),
    .in_accept           (in_accept),
    .in_byte             (in_byte),
    .long_length_type_we (long_length_type_we),
    .long_length_type    (long_length_type),
    .rec_valid           (rec_valid),
    .rec                 (rec)
  );

  tsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (rec_valid),
    .wr_data   (rec),
    .full      (full),
    .rd_en     (q_rd),
    .not_empty (q_not_empty),
    .rd_data   (q_data)
  );

  tsd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_data      (q_data),
    .q_rd        (q_rd),
    .pop         (pop),
    .empty       (empty),
    .out_rec     (out_rec)
  );

  assign packet_type     = out_rec.packet_type;
  assign payload_byte    = out_rec.payload_byte;
  assign first_of_packet = out_rec.first_of_packet;
  assign last_of_packet  = out_rec.last_of_packet;
  assign empty_packet    = out_rec.empty_packet;

endmodule

// File: dv/tsd_deframe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_deframe_checker
// watches the byte input, the result channel and the config write of the
// deframer, rebuilds the expected packet results and compares them in order
// ----------------------------------------------------------------------------
module tsd_deframe_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] in_byte,
  input  logic       pop,
  input  logic       empty,
  input  logic [7:0] packet_type,
  input  logic [7:0] payload_byte,
  input  logic       first_of_packet,
  input  logic       last_of_packet,
  input  logic       empty_packet,
  input  logic       cfg_we,
  input  logic [7:0] cfg_long_type,
  output int         waiting_cnt,
  output int         fail_count
);
  import tsd_pkg::*;

  typedef enum logic [1:0] {
    WAIT_TYPE,
    TAKE_LEN,
    PASS_PAYLOAD
  } parse_phase_t;

  // mirror of the block state
  logic [7:0]   long_code;
  parse_phase_t parse_ph;
  logic [7:0]   cur_ptype;
  logic [2:0]   len_to_go;
  logic [31:0]  len_sum;
  logic [31:0]  pay_to_go;
  logic         next_is_first;

  tsd_rec_t     pending_recs[$];
  int           n_fail = 0;

  task automatic deframe_byte(input logic [7:0] b);
    tsd_rec_t rec;
    case (parse_ph)
      TAKE_LEN: begin
        len_sum   = {len_sum[23:0], b};
        len_to_go = len_to_go - 3'd1;
        if (len_to_go == 3'd0) begin
          if (len_sum == 32'd0) begin
            // zero length gives a single marker result
            rec.packet_type     = cur_ptype;
            rec.payload_byte    = 8'h00;
            rec.first_of_packet = 1'b1;
            rec.last_of_packet  = 1'b1;
            rec.empty_packet    = 1'b1;
            pending_recs.insert(pending_recs.size(), rec);
            parse_ph = WAIT_TYPE;
          end else begin
            pay_to_go     = len_sum;
            next_is_first = 1'b1;
            parse_ph      = PASS_PAYLOAD;
          end
        end
      end
      PASS_PAYLOAD: begin
        rec.packet_type     = cur_ptype;
        rec.payload_byte    = b;
        rec.first_of_packet = next_is_first;
        rec.last_of_packet  = (pay_to_go == 32'd1);
        rec.empty_packet    = 1'b0;
        pending_recs.insert(pending_recs.size(), rec);
        pay_to_go     = pay_to_go - 32'd1;
        next_is_first = 1'b0;
        if (pay_to_go == 32'd0) begin
          parse_ph      = WAIT_TYPE;
          next_is_first = 1'b1;
        end
      end
      default: begin
        // type byte picks the width of the length field
        cur_ptype = b;
        len_to_go = (b == long_code) ? 3'(HDR_LONG_BYTES - 1) : 3'(HDR_SHORT_BYTES - 1);
        len_sum   = 32'd0;
        parse_ph  = TAKE_LEN;
      end
    endcase
  endtask

  always @(posedge clk) begin
    tsd_rec_t want;
    if (rst) begin
      long_code     = 8'h00;
      parse_ph      = WAIT_TYPE;
      cur_ptype     = 8'h00;
      len_to_go     = 3'd0;
      len_sum       = 32'd0;
      pay_to_go     = 32'd0;
      next_is_first = 1'b1;
      pending_recs.delete();
    end else begin
      if (pop && !empty) begin
        if (pending_recs.size() == 0) begin
          $error("result with none expected: type %0h byte %0h", packet_type, payload_byte);
          n_fail++;
        end else begin
          want = pending_recs.pop_front();
          if (packet_type !== want.packet_type) begin
            $error("packet_type: expected %0h, got %0h", want.packet_type, packet_type);
            n_fail++;
          end
          if (payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %0h, got %0h", want.payload_byte, payload_byte);
            n_fail++;
          end
          if (first_of_packet !== want.first_of_packet) begin
            $error("first_of_packet: expected %0b, got %0b", want.first_of_packet,
                   first_of_packet);
            n_fail++;
          end
          if (last_of_packet !== want.last_of_packet) begin
            $error("last_of_packet: expected %0b, got %0b", want.last_of_packet,
                   last_of_packet);
            n_fail++;
          end
          if (empty_packet !== want.empty_packet) begin
            $error("empty_packet: expected %0b, got %0b", want.empty_packet, empty_packet);
            n_fail++;
          end
        end
      end
      if (push && !full) begin
        deframe_byte(in_byte);
      end
      // the register is read only when a type byte arrives
      if (cfg_we) begin
        long_code = cfg_long_type;
      end
    end
    waiting_cnt <= pending_recs.size();
    fail_count  <= n_fail;
  end

endmodule

// File: dv/tlv_stream_deframer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlv_stream_deframer_unit_test
// drives framed byte streams into the deframer under several long-length
// type codes, with random stalls on both sides, and reports the verdict
// ----------------------------------------------------------------------------
module tlv_stream_deframer_unit_test;

  localparam int IDLE_LIMIT  = 3000;
  localparam int SETTLE_CYC  = 8;
  localparam int HOLD_CYC    = 300;
  localparam int PHASE_BYTES = 140;

  logic       clk = 1'b0;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] in_byte;
  logic       pop;
  logic       empty;
  logic [7:0] packet_type;
  logic [7:0] payload_byte;
  logic       first_of_packet;
  logic       last_of_packet;
  logic       empty_packet;
  logic       cfg_we;
  logic [7:0] cfg_long_type;

  int         waiting_cnt;
  int         fail_count;
  int         idle_cycles = 0;
  int         bytes_sent  = 0;
  int         results_taken = 0;
  logic [7:0] cur_long;
  bit         tx_burst = 0;
  bit         rx_burst = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tlv_stream_deframer_unit u_top (
    .clk                 (clk),
    .rst                 (rst),
    .push                (push),
    .full                (full),
    .in_byte             (in_byte),
    .pop                 (pop),
    .empty               (empty),
    .packet_type         (packet_type),
    .payload_byte        (payload_byte),
    .first_of_packet     (first_of_packet),
    .last_of_packet      (last_of_packet),
    .empty_packet        (empty_packet),
    .long_length_type_we (cfg_we),
    .long_length_type    (cfg_long_type)
  );

  tsd_deframe_checker u_chk (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .in_byte         (in_byte),
    .pop             (pop),
    .empty           (empty),
    .packet_type     (packet_type),
    .payload_byte    (payload_byte),
    .first_of_packet (first_of_packet),
    .last_of_packet  (last_of_packet),
    .empty_packet    (empty_packet),
    .cfg_we          (cfg_we),
    .cfg_long_type   (cfg_long_type),
    .waiting_cnt     (waiting_cnt),
    .fail_count      (fail_count)
  );

  // mostly short gaps, a few long ones
  function automatic int pick_gap(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap(tx_burst);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  task automatic send_header(input logic [7:0] t, input logic [31:0] len);
    send_byte(t);
    if (t == cur_long) begin
      send_byte(len[31:24]);
      send_byte(len[23:16]);
    end
    send_byte(len[15:8]);
    send_byte(len[7:0]);
  endtask

  // header bytes make no result, so the parser may still be busy after drain
  task automatic set_long_type(input logic [7:0] v);
    push <= 1'b0;
    do @(posedge clk); while (waiting_cnt != 0);
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_we        <= 1'b1;
    cfg_long_type <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_long = v;
  endtask

  task automatic send_random_packet();
    logic [7:0]  t;
    logic [31:0] len;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      t = cur_long;
    end else if (r < 50) begin
      t = (r < 45) ? 8'h00 : 8'hFF;
    end else begin
      t = 8'($urandom_range(0, 255));
    end
    r = $urandom_range(0, 99);
    if (r < 12) begin
      len = 0;
    end else if (r < 80) begin
      len = $urandom_range(1, 6);
    end else if (r < 96) begin
      len = $urandom_range(7, 40);
    end else begin
      len = $urandom_range(200, 300);
    end
    tx_burst = ($urandom_range(0, 4) == 0);
    send_header(t, len);
    repeat (len) send_byte(8'($urandom_range(0, 255)));
  endtask

  // stimulus
  initial begin
    int         target;
    logic [7:0] v;
    rst           = 1'b1;
    push          = 1'b0;
    in_byte       = 8'h00;
    pop           = 1'b0;
    cfg_we        = 1'b0;
    cfg_long_type = 8'h00;
    cur_long      = 8'h00;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset code 0 selects the four-byte length
    send_header(8'h00, 2);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_header(8'hFF, 0);
    set_long_type(8'hFF);
    send_header(8'hFF, 0);
    send_header(8'h00, 2);
    send_byte(8'h80);
    send_byte(8'h7F);
    // register moved after the type byte must not change this packet
    send_byte(8'hFF);
    set_long_type(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h3C);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       v = 8'hFF;
        1:       v = 8'h00;
        4:       v = 8'h80;
        default: v = 8'($urandom_range(0, 255));
      endcase
      set_long_type(v);
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) send_random_packet();
    end

    push <= 1'b0;
    do @(posedge clk); while (waiting_cnt != 0);
    repeat (SETTLE_CYC) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // result side, with one long hold-off now and then to back up the input
  initial begin
    int gap;
    int hold_at;
    hold_at = 150;
    while (rst) @(posedge clk);
    forever begin
      if (results_taken >= hold_at) begin
        pop <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
        hold_at = hold_at + 400;
      end
      if (results_taken % 50 == 0) begin
        rx_burst = ($urandom_range(0, 3) == 0);
      end
      gap = pick_gap(rx_burst);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      results_taken++;
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

// File: tlv_stream_deframer_unit.f
src/tsd_pkg.sv
src/tsd_front.sv
src/tsd_queue.sv
src/tsd_back.sv
src/tlv_stream_deframer_unit.sv
dv/tsd_deframe_checker.sv
dv/tlv_stream_deframer_unit_test.sv
